// ----- design/pid_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_pkg
// Types, constants and helpers shared by the position PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int GAIN_W  = 24;
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int ERR_W   = 33;
    localparam int ACC_W   = 64;
    localparam int TERM_W  = 34;
    localparam int FF_W    = 56;
    localparam int SUM_W   = 58;
    localparam int DRIVE_W = 16;
    localparam int OPB_W   = 34;
    localparam int REM_W   = 35;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(OPB_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(ACC_W);

    localparam logic [31:0] PERIOD_RST = 32'd10000;

    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_GAIN_FF = 3'd3;
    localparam logic [2:0] REG_PERIOD  = 3'd4;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic [ACC_W-1:0]   a;
        logic [OPB_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic [ACC_W-1:0]   res;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_P,
        ST_IACC,
        ST_ILIM,
        ST_IMUL,
        ST_DMUL,
        ST_DDIV,
        ST_FF,
        ST_SUM,
        ST_OUT
    } t_state;

    // signed magnitude to +-1.0 clamped term (1.0 = 2^32)
    function automatic logic signed [TERM_W-1:0] clamp_mag(input logic [ACC_W-1:0] m,
                                                           input logic neg);
        logic [TERM_W-1:0] v;
        if (m > (ACC_W'(1) << 32)) begin
            v = TERM_W'(1) << 32;
        end else begin
            v = m[TERM_W-1:0];
        end
        return neg ? -$signed(v) : $signed(v);
    endfunction

endpackage

// ----- design/pid_position_controller.sv -----
// ----------------------------------------------------------------------------
// pid_position_controller
// Position PID loop with feedforward; one update per accepted request when
// the update period has elapsed.
// ----------------------------------------------------------------------------
// Each update runs on the shared ALU: P multiply, error times dt multiply,
// I limit divide, I multiply, D multiply, D divide by dt, then FF multiply.
// A clamped I skips the I multiply; zero I gain skips the I limit divide and
// the I multiply. A request that causes no update keeps the loop in idle.
// A held drive stalls the loop. One request at a time; ready only in idle.
// Reset (synchronous, active low): gains 0, period 10000, loop state cleared.
module pid_position_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // target_pos, measured_pos, now_ticks
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // drive, error_out, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = pid_pkg::ACC_W;
    localparam int TW = pid_pkg::TERM_W;

    pid_pkg::t_state   r_state, n_state;
    pid_pkg::t_alu_req alu_req;
    pid_pkg::t_alu_rsp alu_rsp;

    logic signed [23:0] r_gp, r_gi, r_gd, r_gff;
    logic [31:0]        r_period;

    logic signed [31:0] r_tgt, n_tgt;
    logic signed [31:0] r_meas, n_meas;
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_dt, n_dt;
    logic signed [32:0] r_err, n_err;
    logic signed [32:0] r_prev, n_prev;
    logic signed [63:0] r_integ, n_integ;
    logic [31:0]        r_last, n_last;
    logic signed [TW-1:0] r_p, n_p, r_i, n_i, r_d, n_d;
    logic signed [pid_pkg::FF_W-1:0] r_f, n_f;
    logic               r_sneg, n_sneg;
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_drive, n_drive;
    logic signed [32:0] r_oerr, n_oerr;

    logic [31:0]        in_dt;
    logic signed [32:0] err_in;
    logic signed [33:0] diff;
    logic [23:0]        gp_m, gi_m, gd_m, gff_m;
    logic [32:0]        err_m;
    logic [33:0]        diff_m;
    logic [31:0]        tgt_m;
    logic [63:0]        integ_m;
    logic signed [65:0] sat_t;
    logic signed [63:0] integ_new;
    logic signed [pid_pkg::SUM_W-1:0] sum;
    logic signed [TW-1:0] sum_c;
    logic signed [TW:0]   rnd;

    pid_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp     <= '0;
            r_gi     <= '0;
            r_gd     <= '0;
            r_gff    <= '0;
            r_period <= pid_pkg::PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pid_pkg::REG_GAIN_P:  r_gp     <= i_cfg_data[23:0];
                pid_pkg::REG_GAIN_I:  r_gi     <= i_cfg_data[23:0];
                pid_pkg::REG_GAIN_D:  r_gd     <= i_cfg_data[23:0];
                pid_pkg::REG_GAIN_FF: r_gff    <= i_cfg_data[23:0];
                pid_pkg::REG_PERIOD:  r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pid_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_prev   <= '0;
            r_integ  <= '0;
            r_last   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_prev   <= n_prev;
            r_integ  <= n_integ;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_meas  <= n_meas;
        r_now   <= n_now;
        r_dt    <= n_dt;
        r_err   <= n_err;
        r_p     <= n_p;
        r_i     <= n_i;
        r_d     <= n_d;
        r_f     <= n_f;
        r_sneg  <= n_sneg;
        r_drive <= n_drive;
        r_oerr  <= n_oerr;
    end

    assign in_dt   = s_axis_tdata[95:64] - r_last;
    assign err_in  = 33'(r_tgt) - 33'(r_meas);
    assign diff    = 34'(r_err) - 34'(r_prev);
    assign gp_m    = r_gp[23] ? 24'(-r_gp) : r_gp;
    assign gi_m    = r_gi[23] ? 24'(-r_gi) : r_gi;
    assign gd_m    = r_gd[23] ? 24'(-r_gd) : r_gd;
    assign gff_m   = r_gff[23] ? 24'(-r_gff) : r_gff;
    assign err_m   = r_err[32] ? 33'(-r_err) : r_err;
    assign diff_m  = diff[33] ? 34'(-diff) : diff;
    assign tgt_m   = r_tgt[31] ? 32'(-r_tgt) : r_tgt;
    assign integ_m = r_integ[63] ? 64'(-r_integ) : r_integ;

    // saturating integral update
    assign sat_t = r_err[32] ? 66'(r_integ) - $signed({2'b00, alu_rsp.res})
                             : 66'(r_integ) + $signed({2'b00, alu_rsp.res});
    always_comb begin
        if (sat_t > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
            integ_new = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (sat_t < -66'sh0_8000_0000_0000_0000) begin
            integ_new = 64'sh8000_0000_0000_0000;
        end else begin
            integ_new = sat_t[63:0];
        end
    end

    assign sum = pid_pkg::SUM_W'(r_p) + pid_pkg::SUM_W'(r_i) + pid_pkg::SUM_W'(r_d)
               + pid_pkg::SUM_W'(r_f);
    always_comb begin
        if (sum > (pid_pkg::SUM_W'(1) <<< 32)) begin
            sum_c = TW'(1) <<< 32;
        end else if (sum < -(pid_pkg::SUM_W'(1) <<< 32)) begin
            sum_c = -(TW'(1) <<< 32);
        end else begin
            sum_c = sum[TW-1:0];
        end
    end
    assign rnd = (TW+1)'(sum_c) + (TW+1)'(131072);

    always_comb begin
        n_state  = r_state;
        n_tgt    = r_tgt;
        n_meas   = r_meas;
        n_now    = r_now;
        n_dt     = r_dt;
        n_err    = r_err;
        n_prev   = r_prev;
        n_integ  = r_integ;
        n_last   = r_last;
        n_p      = r_p;
        n_i      = r_i;
        n_d      = r_d;
        n_f      = r_f;
        n_sneg   = r_sneg;
        n_drive  = r_drive;
        n_oerr   = r_oerr;
        n_ovalid = r_ovalid && !m_axis_tready;
        alu_req  = '{start: 1'b0, op: pid_pkg::ALU_MUL, a: '0, b: '0};
        s_axis_tready = 1'b0;

        case (r_state)
            pid_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_tgt  = s_axis_tdata[31:0];
                    n_meas = s_axis_tdata[63:32];
                    n_now  = s_axis_tdata[95:64];
                    n_dt   = in_dt;
                    if (in_dt > r_period) begin
                        n_state = pid_pkg::ST_ERR;
                    end
                end
            end
            pid_pkg::ST_ERR: begin
                n_err = err_in;
                if (err_in == '0) begin
                    n_integ = '0;
                    n_prev  = '0;
                end
                n_state = pid_pkg::ST_P;
            end
            pid_pkg::ST_P: begin
                if (!alu_rsp.done) begin
                    alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                a: AW'(gp_m), b: 34'(err_m)};
                end
                n_state = pid_pkg::ST_IACC;
            end
            pid_pkg::ST_IACC: begin
                if (alu_rsp.done) begin
                    n_p = pid_pkg::clamp_mag(alu_rsp.res, r_gp[23] ^ r_err[32]);
                    alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                a: AW'(err_m), b: 34'(r_dt)};
                    n_state = pid_pkg::ST_ILIM;
                end
            end
            pid_pkg::ST_ILIM: begin
                if (alu_rsp.done) begin
                    n_integ = integ_new;
                    if (r_gi == '0) begin
                        n_i = '0;
                        n_sneg = r_gd[23] ^ diff[33];
                        alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                    a: AW'(gd_m), b: diff_m};
                        n_state = pid_pkg::ST_DDIV;
                    end else begin
                        alu_req = '{start: 1'b1, op: pid_pkg::ALU_DIV,
                                    a: AW'(1) << 32, b: 34'(gi_m)};
                        n_state = pid_pkg::ST_IMUL;
                    end
                end
            end
            pid_pkg::ST_IMUL: begin
                if (alu_rsp.done) begin
                    if (integ_m > alu_rsp.res) begin
                        n_i = (r_gi[23] ^ r_integ[63]) ? -(TW'(1) <<< 32) : (TW'(1) <<< 32);
                        n_integ = r_integ[63] ? -$signed(alu_rsp.res) : $signed(alu_rsp.res);
                        n_sneg = r_gd[23] ^ diff[33];
                        alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                    a: AW'(gd_m), b: diff_m};
                        n_state = pid_pkg::ST_DDIV;
                    end else begin
                        n_sneg = r_gi[23] ^ r_integ[63];
                        alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                    a: integ_m, b: 34'(gi_m)};
                        n_state = pid_pkg::ST_DMUL;
                    end
                end
            end
            pid_pkg::ST_DMUL: begin
                if (alu_rsp.done) begin
                    n_i = r_sneg ? -$signed(alu_rsp.res[TW-1:0]) : $signed(alu_rsp.res[TW-1:0]);
                    n_sneg = r_gd[23] ^ diff[33];
                    alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                a: AW'(gd_m), b: diff_m};
                    n_state = pid_pkg::ST_DDIV;
                end
            end
            pid_pkg::ST_DDIV: begin
                if (alu_rsp.done) begin
                    alu_req = '{start: 1'b1, op: pid_pkg::ALU_DIV,
                                a: alu_rsp.res, b: 34'(r_dt)};
                    n_state = pid_pkg::ST_FF;
                end
            end
            pid_pkg::ST_FF: begin
                if (alu_rsp.done) begin
                    n_d = pid_pkg::clamp_mag(alu_rsp.res, r_sneg);
                    n_sneg = r_gff[23] ^ r_tgt[31];
                    alu_req = '{start: 1'b1, op: pid_pkg::ALU_MUL,
                                a: AW'(gff_m), b: 34'(tgt_m)};
                    n_state = pid_pkg::ST_SUM;
                end
            end
            pid_pkg::ST_SUM: begin
                if (alu_rsp.done) begin
                    n_f = r_sneg ? -$signed(alu_rsp.res[pid_pkg::FF_W-1:0])
                                 : $signed(alu_rsp.res[pid_pkg::FF_W-1:0]);
                    n_state = pid_pkg::ST_OUT;
                end
            end
            pid_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_drive  = rnd[TW-1:18];
                    n_oerr   = r_err;
                    n_ovalid = 1'b1;
                    n_prev   = r_err;
                    n_last   = r_now;
                    n_state  = pid_pkg::ST_IDLE;
                end
            end
            default: n_state = pid_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_oerr, r_drive};

endmodule

// ----- design/pid_alu.sv -----
// ----------------------------------------------------------------------------
// pid_alu
// Shared shift-add multiplier and restoring divider on unsigned magnitudes.
// ----------------------------------------------------------------------------
module pid_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pid_pkg::t_alu_req i_req,
    output pid_pkg::t_alu_rsp o_rsp
);

    logic                         r_busy;
    pid_pkg::t_alu_op             r_op;
    logic [pid_pkg::CNT_W-1:0]    r_cnt;
    logic [pid_pkg::ACC_W-1:0]    r_a;
    logic [pid_pkg::OPB_W-1:0]    r_b;
    logic [pid_pkg::ACC_W-1:0]    r_acc;
    logic [pid_pkg::REM_W-1:0]    r_rem;
    logic [pid_pkg::REM_W-1:0]    rem_sh;
    logic                         ge;

    assign rem_sh = {r_rem[pid_pkg::REM_W-2:0], r_acc[pid_pkg::ACC_W-1]};
    assign ge     = rem_sh >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_rem  <= '0;
            if (i_req.op == pid_pkg::ALU_MUL) begin
                r_acc <= '0;
                r_cnt <= pid_pkg::MUL_STEPS;
            end else begin
                r_acc <= i_req.a;
                r_cnt <= pid_pkg::DIV_STEPS;
            end
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_op == pid_pkg::ALU_MUL) begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end else begin
                    r_rem <= ge ? rem_sh - {1'b0, r_b} : rem_sh;
                    r_acc <= {r_acc[pid_pkg::ACC_W-2:0], ge};
                end
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.res  = r_acc;

endmodule

// ----- dv/pid_position_checker.sv -----
// ----------------------------------------------------------------------------
// pid_position_checker
// Watches the request, drive and register channels of the position PID loop,
// keeps its own copy of gains and loop state, and compares every drive
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pid_position_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_updates
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] drive;
        logic signed [32:0] err;
    } t_drive_res;

    t_drive_res drive_q[$];

    logic signed [63:0] kp, ki, kd, kff;
    logic [31:0]        period;
    logic signed [63:0] integ, prev_err;
    logic [31:0]        last_t;

    localparam logic signed [63:0] ONE = 64'sd1 <<< 32;

    function automatic logic signed [63:0] lim1(input logic signed [63:0] v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic predict_update(input logic [95:0] d);
        logic signed [63:0] tgt, meas, e, p, iv, dv, f, s, sum_i;
        logic [63:0]        m, gm, lim, am;
        logic [31:0]        dt;
        logic [127:0]       full;
        logic [63:0]        q;
        t_drive_res         r;
        tgt  = 64'(signed'(d[31:0]));
        meas = 64'(signed'(d[63:32]));
        dt   = d[95:64] - last_t;
        if (!(dt > period)) return;
        e = tgt - meas;
        if (e == 0) begin
            integ = 0;
            prev_err = 0;
        end
        p = lim1(kp * e);
        m = (e < 0 ? -e : e) * 64'(dt);
        full = 128'(signed'(integ)) + (e < 0 ? -128'(m) : 128'(m));
        if ($signed(full) > 128'sh7fffffffffffffff) integ = 64'sh7fffffffffffffff;
        else if ($signed(full) < -128'sh8000000000000000) integ = 64'sh8000000000000000;
        else integ = full[63:0];
        if (ki == 0) begin
            iv = 0;
        end else begin
            gm  = ki < 0 ? -ki : ki;
            lim = (64'd1 << 32) / gm;
            am  = integ < 0 ? -integ : integ;
            if (am > lim) begin
                iv = ((ki < 0) != (integ < 0)) ? -ONE : ONE;
                integ = integ < 0 ? -$signed(lim) : $signed(lim);
            end else begin
                iv = ki * integ;
            end
        end
        dv = lim1((kd * (e - prev_err)) / $signed({32'd0, dt}));
        f = kff * tgt;
        s = lim1(p + iv + dv + f);
        q = ((s + ONE) + (64'd1 << 17)) >> 18;
        prev_err = e;
        last_t = d[95:64];
        r.drive = 16'(q - 64'd16384);
        r.err = e[32:0];
        drive_q.push_back(r);
    endtask

    assign o_pending = drive_q.size();

    always @(posedge i_clk) begin
        t_drive_res w;
        if (!i_rst_n) begin
            kp = 0; ki = 0; kd = 0; kff = 0;
            period = pid_pkg::PERIOD_RST;
            integ = 0; prev_err = 0; last_t = 0;
            drive_q.delete();
            o_fail_count = 0;
            o_updates = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pid_pkg::REG_GAIN_P:  kp  = 64'(signed'(i_cfg_data[23:0]));
                    pid_pkg::REG_GAIN_I:  ki  = 64'(signed'(i_cfg_data[23:0]));
                    pid_pkg::REG_GAIN_D:  kd  = 64'(signed'(i_cfg_data[23:0]));
                    pid_pkg::REG_GAIN_FF: kff = 64'(signed'(i_cfg_data[23:0]));
                    pid_pkg::REG_PERIOD:  period = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_updates++;
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected drive", 64'(m_axis_tdata), 0);
                end else begin
                    w = drive_q.pop_front();
                    if (m_axis_tdata[15:0] !== w.drive)
                        report_mismatch("drive", 64'(m_axis_tdata[15:0]), 64'(w.drive));
                    if (m_axis_tdata[48:16] !== w.err)
                        report_mismatch("error_out", 64'(m_axis_tdata[48:16]), 64'(w.err));
                    if (m_axis_tdata[55:49] !== 7'd0)
                        report_mismatch("pad", 64'(m_axis_tdata[55:49]), 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_update(s_axis_tdata);
        end
    end
endmodule

// ----- dv/tb_pid_position_controller.sv -----
// ----------------------------------------------------------------------------
// tb_pid_position_controller
// Drives requests and register writes into the position PID loop under
// varied gains and periods, with random idling and back-pressure; the
// checker predicts every drive result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_pid_position_controller;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes with no register behind them
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count, pending, updates;
    int          src_idle = 0, snk_idle = 0;
    bit          hold_sink = 0;
    int          idle_cycles = 0;
    logic [31:0] clock_ticks = 0;
    int          requests = 0;

    pid_position_controller uut (.*);

    pid_position_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending),
        .o_updates(updates)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (hold_sink) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else if (!hold_sink)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_request(input logic [31:0] tgt, input logic [31:0] meas,
                                input logic [31:0] ticks);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {ticks, meas, tgt};
        do @(posedge i_clk); while (!s_axis_tready);
        requests++;
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos(input int small_range);
        if (small_range) return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
        return $urandom;
    endfunction

    task automatic set_gains(input logic [31:0] p, input logic [31:0] ig,
                             input logic [31:0] d, input logic [31:0] ff,
                             input logic [31:0] per);
        drain();
        write_reg(pid_pkg::REG_GAIN_P, p);
        write_reg(pid_pkg::REG_GAIN_I, ig);
        write_reg(pid_pkg::REG_GAIN_D, d);
        write_reg(pid_pkg::REG_GAIN_FF, ff);
        write_reg(pid_pkg::REG_PERIOD, per);
    endtask

    function automatic logic [31:0] rand_gain;
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(512)) - 256);
            1: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
            2: return $urandom;
            default: return $urandom_range(1) ? 32'h7fffff : 32'h800000;
        endcase
    endfunction

    initial begin
        logic [31:0] tg;
        int phase;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset period, then extremes, zero error, wrap, period zero
        send_request(32'h7fffffff, 32'h80000000, 32'd10001);
        send_request(32'd5, 32'd5, 32'd15000);
        set_gains(32'h7fffff, 32'h800000, 32'h7fffff, 32'h800000, 32'd0);
        write_reg(REG_SPARE_LO, 32'hffffffff);
        write_reg(REG_SPARE_HI, 32'h12345678);
        send_request(32'h80000000, 32'h7fffffff, 32'd20001);
        send_request(32'h80000000, 32'h7fffffff, 32'd20001);
        send_request(32'h0, 32'h0, 32'd20002);
        send_request(32'h7fffffff, 32'h0, 32'hffffffff);
        send_request(32'h7fffffff, 32'h7ffffffe, 32'd3);
        set_gains(32'h10000, 32'h1, 32'h10000, 32'h100, 32'hffffffff);
        send_request(32'h1000, 32'h0, 32'd100);
        set_gains(32'h10000, 32'h7fffff, 32'h1, 32'h0, 32'd1);
        send_request(32'h1000, 32'h0, 32'd2);
        send_request(32'h800, 32'h1000, 32'd4);
        send_request(32'hffff_0000, 32'h0, 32'd400000);
        send_request(32'h0, 32'h1, 32'd400002);
        // long receiver hold while the sender keeps offering requests
        drain();
        hold_sink = 1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 6; k++)
                send_request(rand_pos(1), rand_pos(1), clock_ticks + 32'd1000 * (k + 1));
        join
        clock_ticks = clock_ticks + 32'd10000;

        for (phase = 0; phase < 3; phase++) begin
            src_idle = phase == 0 ? 29 : phase == 1 ? 66 : 0;
            snk_idle = phase == 0 ? 66 : phase == 1 ? 29 : 0;
            for (int blk = 0; blk < 7; blk++) begin
                set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          $urandom_range(3) == 0 ? $urandom : $urandom_range(50));
                for (int n = 0; n < 40; n++) begin
                    case ($urandom_range(9))
                        0: clock_ticks = $urandom;
                        1: clock_ticks = clock_ticks + 32'd1;
                        default: clock_ticks = clock_ticks + $urandom_range(120);
                    endcase
                    tg = rand_pos($urandom_range(2) != 0);
                    send_request(tg, $urandom_range(5) == 0 ? tg : rand_pos($urandom_range(2) != 0),
                                 clock_ticks);
                end
            end
        end

        drain();
        $display("covered %0d requests, %0d drive updates, three idling phases", requests,
                 updates);
        $display("gains at extremes, period zero and maximum, timer wrap, long stall");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
